// ===== sv/adrc_pkg.sv =====
// Shared types, codes and helpers for the ADRC speed controller.
// Used by adrc_mul_unit and adrc_speed_controller_core; no dependencies.
package adrc_pkg;

    // Operand and value widths
    localparam int A_W = 41;  // magnitude operand
    localparam int B_W = 56;  // unsigned coefficient operand
    localparam int V_W = 40;  // saturated signed state value

    // Post-product right shift selection
    localparam logic [2:0] SH_NONE = 3'd0;
    localparam logic [2:0] SH_8    = 3'd1;
    localparam logic [2:0] SH_16   = 3'd2;
    localparam logic [2:0] SH_24   = 3'd3;
    localparam logic [2:0] SH_32   = 3'd4;

    // Configuration register indexes
    localparam logic [3:0] REG_TARGET_SPEED   = 4'd0;
    localparam logic [3:0] REG_SPEED_SCALE    = 4'd1;
    localparam logic [3:0] REG_STEP_TIME      = 4'd2;
    localparam logic [3:0] REG_OBS_GAIN_ONE   = 4'd3;
    localparam logic [3:0] REG_OBS_GAIN_TWO   = 4'd4;
    localparam logic [3:0] REG_TRACKING_GAIN  = 4'd5;
    localparam logic [3:0] REG_CONTROL_GAIN   = 4'd6;
    localparam logic [3:0] REG_INV_CTRL_GAIN  = 4'd7;

    typedef struct packed {
        logic           start;
        logic [A_W-1:0] a_mag;
        logic           neg;
        logic [B_W-1:0] b;
        logic [2:0]     shift;
        logic           a_two;  // magnitude needs both 32-bit limbs
        logic           b_two;  // coefficient needs both limbs
    } mul_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [V_W-1:0] res;
        logic [B_W-1:0]        raw;
    } mul_rsp_t;

    function automatic logic signed [V_W-1:0] sat40(input logic signed [V_W+1:0] v);
        logic signed [V_W-1:0] r;
        if (v[V_W+1:V_W-1] == 3'b000 || v[V_W+1:V_W-1] == 3'b111) begin
            r = v[V_W-1:0];
        end else if (v[V_W+1]) begin
            r = {1'b1, {(V_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(V_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [V_W-1:0] v);
        logic [31:0] r;
        if (v[V_W-1:31] == '0 || v[V_W-1:31] == '1) begin
            r = v[31:0];
        end else if (v[V_W-1]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [V_W+1:0] sx42(input logic signed [V_W-1:0] v);
        logic signed [V_W+1:0] r;
        r = {{2{v[V_W-1]}}, v};
        return r;
    endfunction

    function automatic logic [A_W-1:0] abs41(input logic signed [A_W-1:0] v);
        logic [A_W-1:0] r;
        r = v[A_W-1] ? (~v + {{(A_W-1){1'b0}}, 1'b1}) : v;
        return r;
    endfunction

endpackage

// ===== sv/adrc_speed_controller_core.sv =====
// Top level of the ADRC speed controller: configuration registers, observer
// state, step sequencer and output register. Uses adrc_pkg and adrc_mul_unit.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  s_      | in        | s_tvalid / s_tready   | s_tdata: edge_count
//  m_      | out       | m_tvalid / m_tready   | m_tdata: pwm_duty, measured_speed,
//          |           |                       |   speed_estimate, disturbance_estimate
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A tick runs from its acceptance to the result showing on m_tvalid; s_tready
// rises in that same cycle, so a new tick is taken only once the last is out. The
// tick runs on the single 32x32 multiplier: nine products, sixteen limb products
// in all, each product running its limb products and then accumulate, shift,
// saturate and handoff steps, between the sequencer's own steps.
// s_tready is high only while the sequencer idles; a stalled result holds the
// sequencer before the output register. Reset (aresetn low, synchronous) clears
// the observer state and loads the register defaults; cfg_ready is always high.
module adrc_speed_controller_core import adrc_pkg::*; #(
    parameter  int DUTY_BITS = 13,
    localparam int M_TDATA_W = ((DUTY_BITS + 91 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [14:0] edge_count
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pwm_duty, measured_speed (27), speed_estimate (32), disturbance_estimate (32)
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MEAS = 4'd1;
    localparam logic [3:0] S_ERR  = 4'd2;
    localparam logic [3:0] S_A    = 4'd3;
    localparam logic [3:0] S_B    = 4'd4;
    localparam logic [3:0] S_HB   = 4'd5;
    localparam logic [3:0] S_C    = 4'd6;
    localparam logic [3:0] S_D    = 4'd7;
    localparam logic [3:0] S_U0   = 4'd8;
    localparam logic [3:0] S_DIFF = 4'd9;
    localparam logic [3:0] S_U    = 4'd10;
    localparam logic [3:0] S_DUTY = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    localparam logic [B_W-1:0] DUTY_MAX = B_W'((64'd1 << DUTY_BITS) - 64'd1);
    localparam logic [16:0]    FRAC_ONE = 17'h1_0000;

    // Configuration registers
    logic [26:0] target_speed_reg;
    logic [23:0] speed_scale_reg;
    logic [23:0] step_time_reg;
    logic [23:0] obs_gain_one_reg;
    logic [31:0] obs_gain_two_reg;
    logic [23:0] tracking_gain_reg;
    logic [23:0] control_gain_reg;
    logic [31:0] inv_ctrl_gain_reg;

    // Observer and drive state
    logic signed [V_W-1:0] z1_reg, z2_reg;
    logic [16:0]           u_reg;

    // Per-tick working values
    logic [3:0]            state_reg, state_next;
    logic [26:0]           meas_reg;
    logic signed [A_W-1:0] err_reg;
    logic signed [V_W+1:0] tsum_reg;
    logic signed [V_W-1:0] term_reg;
    logic [B_W-1:0]        hb_reg;
    logic signed [A_W-1:0] diff_reg;
    logic [DUTY_BITS-1:0]  duty_reg;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg, tdata_next;

    mul_req_t              req;
    mul_rsp_t              rsp;
    logic signed [A_W-1:0] track_err;
    logic [16:0]           u_clamp;
    logic                  out_free;

    adrc_mul_unit u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Setpoint error against the fresh speed estimate
    assign track_err = {{(A_W-27){1'b0}}, target_speed_reg} - {z1_reg[V_W-1], z1_reg};

    // Drive fraction clamped to 0..1 in Q1.16
    always_comb begin
        if (rsp.res[V_W-1]) begin
            u_clamp = '0;
        end else if (rsp.res > $signed({{(V_W-17){1'b0}}, FRAC_ONE})) begin
            u_clamp = FRAC_ONE;
        end else begin
            u_clamp = rsp.res[16:0];
        end
    end

    // Sequencer: launch each product, advance on its result, then wait for a free output
    always_comb begin
        state_next = state_reg;
        req        = '0;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) begin
                req.start  = 1'b1;
                req.a_mag  = {{(A_W-15){1'b0}}, s_tdata[14:0]};
                req.b      = {{(B_W-24){1'b0}}, speed_scale_reg};
                req.shift  = SH_8;
                state_next = S_MEAS;
            end
            S_MEAS: if (rsp.done) state_next = S_ERR;
            S_ERR: begin
                req.start  = 1'b1;
                req.a_mag  = {{(A_W-17){1'b0}}, u_reg};
                req.b      = {{(B_W-24){1'b0}}, control_gain_reg};
                req.shift  = SH_16;
                state_next = S_A;
            end
            S_A: if (rsp.done) begin
                req.start  = 1'b1;
                req.a_mag  = abs41(err_reg);
                req.neg    = err_reg[A_W-1];
                req.b      = {{(B_W-24){1'b0}}, obs_gain_one_reg};
                req.shift  = SH_8;
                req.a_two  = 1'b1;
                state_next = S_B;
            end
            S_B: if (rsp.done) begin
                req.start  = 1'b1;
                req.a_mag  = {{(A_W-24){1'b0}}, step_time_reg};
                req.b      = {{(B_W-32){1'b0}}, obs_gain_two_reg};
                req.shift  = SH_NONE;
                state_next = S_HB;
            end
            S_HB: if (rsp.done) begin
                req.start  = 1'b1;
                req.a_mag  = abs41({term_reg[V_W-1], term_reg});
                req.neg    = term_reg[V_W-1];
                req.b      = {{(B_W-24){1'b0}}, step_time_reg};
                req.shift  = SH_24;
                req.a_two  = 1'b1;
                state_next = S_C;
            end
            S_C: if (rsp.done) begin
                req.start  = 1'b1;
                req.a_mag  = abs41(err_reg);
                req.neg    = err_reg[A_W-1];
                req.b      = hb_reg;
                req.shift  = SH_32;
                req.a_two  = 1'b1;
                req.b_two  = 1'b1;
                state_next = S_D;
            end
            S_D: if (rsp.done) begin
                req.start  = 1'b1;
                req.a_mag  = abs41(track_err);
                req.neg    = track_err[A_W-1];
                req.b      = {{(B_W-24){1'b0}}, tracking_gain_reg};
                req.shift  = SH_8;
                req.a_two  = 1'b1;
                state_next = S_U0;
            end
            S_U0: if (rsp.done) state_next = S_DIFF;
            S_DIFF: begin
                req.start  = 1'b1;
                req.a_mag  = abs41(diff_reg);
                req.neg    = diff_reg[A_W-1];
                req.b      = {{(B_W-32){1'b0}}, inv_ctrl_gain_reg};
                req.shift  = SH_24;
                req.a_two  = 1'b1;
                state_next = S_U;
            end
            S_U: if (rsp.done) begin
                req.start  = 1'b1;
                req.a_mag  = {{(A_W-17){1'b0}}, u_clamp};
                req.b      = DUTY_MAX;
                req.shift  = SH_16;
                state_next = S_DUTY;
            end
            S_DUTY: if (rsp.done) state_next = S_OUT;
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        tdata_next = '0;
        tdata_next[DUTY_BITS-1:0]      = duty_reg;
        tdata_next[DUTY_BITS +: 27]    = meas_reg;
        tdata_next[DUTY_BITS+27 +: 32] = sat32(z1_reg);
        tdata_next[DUTY_BITS+59 +: 32] = sat32(z2_reg);
    end

    // Control state, configuration and observer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_tvalid_reg      <= 1'b0;
            target_speed_reg  <= 27'd307200;
            speed_scale_reg   <= 24'd960000;
            step_time_reg     <= 24'd16777;
            obs_gain_one_reg  <= 24'd23040;
            obs_gain_two_reg  <= 32'd518400;
            tracking_gain_reg <= 24'd2560;
            control_gain_reg  <= 24'd102400;
            inv_ctrl_gain_reg <= 32'd10737418;
            z1_reg            <= '0;
            z2_reg            <= '0;
            u_reg             <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                // drop writes beyond the register list
                unique case (cfg_index)
                    REG_TARGET_SPEED:  target_speed_reg  <= cfg_data[26:0];
                    REG_SPEED_SCALE:   speed_scale_reg   <= cfg_data[23:0];
                    REG_STEP_TIME:     step_time_reg     <= cfg_data[23:0];
                    REG_OBS_GAIN_ONE:  obs_gain_one_reg  <= cfg_data[23:0];
                    REG_OBS_GAIN_TWO:  obs_gain_two_reg  <= cfg_data;
                    REG_TRACKING_GAIN: tracking_gain_reg <= cfg_data[23:0];
                    REG_CONTROL_GAIN:  control_gain_reg  <= cfg_data[23:0];
                    REG_INV_CTRL_GAIN: inv_ctrl_gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            // z1 and z2 commit as soon as they are final; later steps read the new ones
            if (state_reg == S_C && rsp.done) begin
                z1_reg <= sat40(sx42(z1_reg) + sx42(rsp.res));
            end
            if (state_reg == S_D && rsp.done) begin
                z2_reg <= sat40(sx42(z2_reg) - sx42(rsp.res));
            end
            if (state_reg == S_U && rsp.done) begin
                u_reg <= u_clamp;
            end
        end
    end

    // Working values
    always_ff @(posedge aclk) begin
        if (state_reg == S_MEAS && rsp.done) begin
            meas_reg <= (|rsp.res[V_W-1:27]) ? '1 : rsp.res[26:0];
        end
        if (state_reg == S_ERR) begin
            err_reg <= {z1_reg[V_W-1], z1_reg} - {{(A_W-27){1'b0}}, meas_reg};
        end
        if (state_reg == S_A && rsp.done) begin
            tsum_reg <= sx42(z2_reg) + sx42(rsp.res);
        end
        if (state_reg == S_B && rsp.done) begin
            term_reg <= sat40(tsum_reg - sx42(rsp.res));
        end
        if (state_reg == S_HB && rsp.done) begin
            hb_reg <= rsp.raw;
        end
        if (state_reg == S_U0 && rsp.done) begin
            diff_reg <= {rsp.res[V_W-1], rsp.res} - {z2_reg[V_W-1], z2_reg};
        end
        if (state_reg == S_DUTY && rsp.done) begin
            duty_reg <= rsp.res[DUTY_BITS-1:0];
        end
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= tdata_next;
        end
    end

endmodule

// ===== sv/adrc_mul_unit.sv =====
// Shared multiply unit: 32x32 limb products accumulated over cycles, then a
// truncating right shift and saturation to signed 40 bits. Uses adrc_pkg.
module adrc_mul_unit import adrc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    localparam int ACC_W = A_W + B_W;

    logic [2:0]            st_reg, st_next;
    logic [A_W-1:0]        a_reg;
    logic [B_W-1:0]        b_reg;
    logic                  neg_reg;
    logic [2:0]            sh_reg;
    logic                  a_two_reg, b_two_reg;
    logic                  i_reg, j_reg;
    logic [63:0]           pp_reg;
    logic [1:0]            off_reg;
    logic                  pp_vld_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic                  hi_reg;
    logic [V_W-1:0]        lo_reg;
    logic signed [V_W-1:0] res_reg;
    logic                  done_reg;

    logic [31:0]      a_limb, b_limb;
    logic [ACC_W-1:0] acc_sum, shifted;
    logic [V_W-1:0]   lim, q;

    assign a_limb = i_reg ? {{(64-A_W){1'b0}}, a_reg[A_W-1:32]} : a_reg[31:0];
    assign b_limb = j_reg ? {{(64-B_W){1'b0}}, b_reg[B_W-1:32]} : b_reg[31:0];

    always_comb begin
        unique case (off_reg)
            2'd0:    acc_sum = acc_reg + {{(ACC_W-64){1'b0}}, pp_reg};
            2'd1:    acc_sum = acc_reg + {{(ACC_W-96){1'b0}}, pp_reg, 32'b0};
            2'd2:    acc_sum = acc_reg + {pp_reg[ACC_W-65:0], 64'b0};
            default: acc_sum = acc_reg;
        endcase
    end

    always_comb begin
        unique case (sh_reg)
            SH_8:    shifted = acc_reg >> 8;
            SH_16:   shifted = acc_reg >> 16;
            SH_24:   shifted = acc_reg >> 24;
            SH_32:   shifted = acc_reg >> 32;
            default: shifted = acc_reg;
        endcase
    end

    // A negative result may reach one step further than a positive one
    assign lim = neg_reg ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};
    assign q   = (hi_reg || lo_reg > lim) ? lim : lo_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (req.start) st_next = ST_RUN;
            ST_RUN:   if (i_reg == a_two_reg && j_reg == b_two_reg) st_next = ST_DRAIN;
            ST_DRAIN: st_next = ST_SHIFT;
            ST_SHIFT: st_next = ST_SAT;
            ST_SAT:   st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            st_reg     <= st_next;
            pp_vld_reg <= (st_reg == ST_RUN);
            done_reg   <= (st_reg == ST_SAT);
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && req.start) begin
            a_reg     <= req.a_mag;
            b_reg     <= req.b;
            neg_reg   <= req.neg;
            sh_reg    <= req.shift;
            a_two_reg <= req.a_two;
            b_two_reg <= req.b_two;
            i_reg     <= 1'b0;
            j_reg     <= 1'b0;
            acc_reg   <= '0;
        end else if (pp_vld_reg) begin
            acc_reg <= acc_sum;
        end
        if (st_reg == ST_RUN) begin
            pp_reg  <= a_limb * b_limb;
            off_reg <= {1'b0, i_reg} + {1'b0, j_reg};
            // walk coefficient limbs inside magnitude limbs
            if (j_reg != b_two_reg) begin
                j_reg <= 1'b1;
            end else begin
                j_reg <= 1'b0;
                i_reg <= 1'b1;
            end
        end
        if (st_reg == ST_SHIFT) begin
            hi_reg <= |shifted[ACC_W-1:V_W];
            lo_reg <= shifted[V_W-1:0];
        end
        if (st_reg == ST_SAT) begin
            res_reg <= neg_reg ? -q : q;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;
    assign rsp.raw  = acc_reg[B_W-1:0];

endmodule
